[sv/rau_pkg.sv]
// Package for the rational arithmetic unit: opcodes, status codes, item kinds and
// the sequencer states of the back end. Used by every module of the block but the queue.
`timescale 1ns / 1ps
package rau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4,
    CMD_INC = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZDEN = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_ARITH = 3'd0,
    K_EQ    = 3'd1,
    K_INC   = 3'd2,
    K_ERR   = 3'd3,
    K_NOP   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FINISH
  } state_t;

  localparam int KIND_BITS = 3;
  localparam int CMD_BITS  = 3;

endpackage

[sv/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit: front end, queue and back end.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
//   channel   handshake            payload
//   command   start / busy         cmd, a_num, a_den, b_num, b_den
//   result    done (one cycle)     res_num, res_den, is_equal, status
//
// Unused opcodes, zero denominators and increment finish in the decode state
// after leaving the queue. Add, subtract, multiply and divide pass through the
// shared multiplier, a sum step, the binary gcd engine and the one-bit-a-cycle
// divider; the equal test runs the gcd and divider twice. busy is high while
// the queue is full. Reset empties the queue and idles the sequencer; results
// cannot be held off by the receiver.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rau_pkg::CMD_BITS-1:0] cmd,
  input  logic [WORD_BITS-1:0]         a_num,
  input  logic [WORD_BITS-1:0]         a_den,
  input  logic [WORD_BITS-1:0]         b_num,
  input  logic [WORD_BITS-1:0]         b_den,
  output logic                         done,
  output logic [WORD_BITS-1:0]         res_num,
  output logic [WORD_BITS-1:0]         res_den,
  output logic                         is_equal,
  output logic [1:0]                   status
);
  import rau_pkg::*;

  localparam int DATA_BITS = KIND_BITS + CMD_BITS + 2 + 4 * WORD_BITS;

  logic [DATA_BITS-1:0] wentry, rentry;
  logic                 full, empty, pop;

  assign busy = full;

  rau_front #(.W(WORD_BITS), .DATA_BITS(DATA_BITS)) u_front (
    .cmd   (cmd),
    .a_num (a_num),
    .a_den (a_den),
    .b_num (b_num),
    .b_den (b_den),
    .entry (wentry)
  );

  rau_queue #(.DATA_BITS(DATA_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (start),
    .wdata (wentry),
    .pop   (pop),
    .rdata (rentry),
    .full  (full),
    .empty (empty)
  );

  rau_back #(.W(WORD_BITS), .DATA_BITS(DATA_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .entry    (rentry),
    .empty    (empty),
    .pop      (pop),
    .done     (done),
    .res_num  (res_num),
    .res_den  (res_den),
    .is_equal (is_equal),
    .status   (status)
  );

endmodule

[sv/rau_front.sv]
// Front end of the rational arithmetic unit: takes a command beat, forms operand
// magnitudes and normalised signs, and classifies the item. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_front #(
  parameter int W = 32,
  parameter int DATA_BITS = rau_pkg::KIND_BITS + rau_pkg::CMD_BITS + 2 + 4 * W
) (
  input  logic [rau_pkg::CMD_BITS-1:0] cmd,
  input  logic [W-1:0]                 a_num,
  input  logic [W-1:0]                 a_den,
  input  logic [W-1:0]                 b_num,
  input  logic [W-1:0]                 b_den,
  output logic [DATA_BITS-1:0]         entry
);
  import rau_pkg::*;

  logic [W-1:0] anm, adm, bnm, bdm;
  logic         sa, sb;
  logic         a_den_zero, b_den_zero, b_num_zero;
  kind_t        kind;

  assign anm = a_num[W-1] ? (~a_num + W'(1)) : a_num;
  assign adm = a_den[W-1] ? (~a_den + W'(1)) : a_den;
  assign bnm = b_num[W-1] ? (~b_num + W'(1)) : b_num;
  assign bdm = b_den[W-1] ? (~b_den + W'(1)) : b_den;

  assign sa = (a_num[W-1] ^ a_den[W-1]) && (a_num != '0);
  assign sb = (b_num[W-1] ^ b_den[W-1]) && (b_num != '0);

  assign a_den_zero = (a_den == '0);
  assign b_den_zero = (b_den == '0);
  assign b_num_zero = (b_num == '0);

  always_comb begin
    if (cmd > CMD_INC) begin
      kind = K_NOP;
    end else if (a_den_zero || ((cmd <= CMD_EQ) && b_den_zero)
                 || ((cmd == CMD_DIV) && b_num_zero)) begin
      kind = K_ERR;
    end else if (cmd == CMD_INC) begin
      kind = K_INC;
    end else if (cmd == CMD_EQ) begin
      kind = K_EQ;
    end else begin
      kind = K_ARITH;
    end
  end

  assign entry = {kind, cmd, sa, sb, anm, adm, bnm, bdm};

endmodule

[sv/rau_queue.sv]
// Short register queue between the front and back ends of the rational
// arithmetic unit. Generic in width and depth; no package dependency.
`timescale 1ns / 1ps
module rau_queue #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] rdata,
  output logic                 full,
  output logic                 empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [AW-1:0]        wr_ptr, rd_ptr;
  logic [CW-1:0]        count;
  logic                 do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[sv/rau_back.sv]
// Back end of the rational arithmetic unit: a sequencer with one shared multiplier,
// a binary gcd engine and a bit-serial divider. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_back #(
  parameter int W = 32,
  parameter int DATA_BITS = rau_pkg::KIND_BITS + rau_pkg::CMD_BITS + 2 + 4 * W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DATA_BITS-1:0] entry,
  input  logic                 empty,
  output logic                 pop,
  output logic                 done,
  output logic [W-1:0]         res_num,
  output logic [W-1:0]         res_den,
  output logic                 is_equal,
  output logic [1:0]           status
);
  import rau_pkg::*;

  localparam int DW = 2 * W;
  localparam int CNTW = $clog2(DW);
  localparam logic [DW-1:0] LIM  = DW'(1) << (W - 1);
  localparam logic [W:0]    LIMW = (W + 1)'(1) << (W - 1);

  state_t state, state_next;

  kind_t        kind;
  cmd_t         op;
  logic         sa, sb;
  logic [W-1:0] anm, adm, bnm, bdm;

  logic [W-1:0]  ma, mb;
  logic [DW-1:0] prod, p0, p1, p2;
  logic [DW-1:0] u, v, nr, dr, quo, rem, nq, dq;
  logic          nsign, pass;
  logic          ra_sign;
  logic [DW-1:0] ra_n, ra_d;
  logic [CNTW-1:0] cnt;

  logic          s0, s1;
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [DW-1:0] quo_next, rem_next;
  logic          fneg, fits;
  logic [W:0]    inc_mag;
  logic          inc_neg, inc_fits;

  assign s0 = ((op == CMD_ADD) || (op == CMD_SUB)) ? sa : (sa ^ sb);
  assign s1 = sb ^ (op == CMD_SUB);

  assign prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};

  assign rem_sh   = {rem, quo[DW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, v});
  assign rem_next = rem_ge ? DW'(rem_sh - {1'b0, v}) : rem_sh[DW-1:0];
  assign quo_next = {quo[DW-2:0], rem_ge};

  assign fneg = nsign && (nq != '0);
  assign fits = (dq <= LIM - DW'(1)) && (fneg ? (nq <= LIM) : (nq <= LIM - DW'(1)));

  always_comb begin
    if (!sa) begin
      inc_mag = {1'b0, anm} + {1'b0, adm};
      inc_neg = 1'b0;
    end else if (anm > adm) begin
      inc_mag = {1'b0, anm} - {1'b0, adm};
      inc_neg = 1'b1;
    end else begin
      inc_mag = {1'b0, adm} - {1'b0, anm};
      inc_neg = 1'b0;
    end
  end

  assign inc_fits = ({1'b0, adm} <= LIMW - (W + 1)'(1))
                    && (inc_neg ? (inc_mag <= LIMW) : (inc_mag <= LIMW - (W + 1)'(1)));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!empty) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (kind)
          K_ARITH: state_next = S_MUL0;
          K_EQ:    state_next = S_GCD;
          default: state_next = S_IDLE;
        endcase
      end
      S_MUL0:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_SUM;
      S_SUM:   state_next = S_GCD;
      S_GCD: begin
        if (u == '0) state_next = S_DIVN;
      end
      S_DIVN: begin
        if (cnt == CNTW'(DW - 1)) state_next = S_DIVD;
      end
      S_DIVD: begin
        if (cnt == CNTW'(DW - 1)) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = ((kind == K_EQ) && !pass) ? S_GCD : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    ma  = '0;
    mb  = '0;
    case (state)
      S_IDLE: pop = !empty;
      S_MUL0: begin
        ma = anm;
        mb = (op == CMD_MUL) ? bnm : bdm;
      end
      S_MUL1: begin
        if ((op == CMD_ADD) || (op == CMD_SUB)) begin
          ma = bnm;
          mb = adm;
        end
      end
      S_MUL2: begin
        ma = adm;
        mb = (op == CMD_DIV) ? bnm : bdm;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == S_DECODE) && (kind != K_ARITH) && (kind != K_EQ))
               || ((state == S_FINISH) && !((kind == K_EQ) && !pass));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!empty) begin
          kind <= kind_t'(entry[DATA_BITS-1 -: KIND_BITS]);
          op   <= cmd_t'(entry[DATA_BITS-KIND_BITS-1 -: CMD_BITS]);
          {sa, sb, anm, adm, bnm, bdm} <= entry[DATA_BITS-KIND_BITS-CMD_BITS-1:0];
        end
      end
      S_DECODE: begin
        is_equal <= 1'b0;
        pass     <= 1'b0;
        u        <= {{W{1'b0}}, anm};
        v        <= {{W{1'b0}}, adm};
        nr       <= {{W{1'b0}}, anm};
        dr       <= {{W{1'b0}}, adm};
        nsign    <= sa;
        case (kind)
          K_ERR: begin
            res_num <= '0;
            res_den <= '0;
            status  <= STAT_ZDEN;
          end
          K_INC: begin
            if (inc_fits) begin
              res_num <= inc_neg ? (~inc_mag[W-1:0] + W'(1)) : inc_mag[W-1:0];
              res_den <= adm;
              status  <= STAT_OK;
            end else begin
              res_num <= '0;
              res_den <= '0;
              status  <= STAT_OVF;
            end
          end
          default: begin
            res_num <= '0;
            res_den <= W'(1);
            status  <= STAT_OK;
          end
        endcase
      end
      S_MUL0: p0 <= prod;
      S_MUL1: p1 <= prod;
      S_MUL2: p2 <= prod;
      S_SUM: begin
        v  <= p2;
        dr <= p2;
        if (s0 == s1) begin
          u <= p0 + p1; nr <= p0 + p1; nsign <= s0;
        end else if (p0 >= p1) begin
          u <= p0 - p1; nr <= p0 - p1; nsign <= s0;
        end else begin
          u <= p1 - p0; nr <= p1 - p0; nsign <= s1;
        end
      end
      S_GCD: begin
        cnt <= '0;
        rem <= '0;
        if (u == '0) begin
          quo <= nr;
        end else if (!u[0] && !v[0]) begin
          u  <= u >> 1;
          v  <= v >> 1;
          nr <= nr >> 1;
          dr <= dr >> 1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
      S_DIVN: begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(DW - 1)) begin
          nq  <= quo_next;
          quo <= dr;
          rem <= '0;
        end else begin
          quo <= quo_next;
          rem <= rem_next;
        end
      end
      S_DIVD: begin
        cnt <= cnt + CNTW'(1);
        quo <= quo_next;
        rem <= rem_next;
        if (cnt == CNTW'(DW - 1)) begin
          dq <= quo_next;
        end
      end
      S_FINISH: begin
        if (kind == K_EQ) begin
          if (!pass) begin
            ra_sign <= fneg;
            ra_n    <= nq;
            ra_d    <= dq;
            pass    <= 1'b1;
            u       <= {{W{1'b0}}, bnm};
            v       <= {{W{1'b0}}, bdm};
            nr      <= {{W{1'b0}}, bnm};
            dr      <= {{W{1'b0}}, bdm};
            nsign   <= sb;
          end else begin
            res_num  <= '0;
            res_den  <= W'(1);
            status   <= STAT_OK;
            is_equal <= (ra_sign == fneg) && (ra_n == nq) && (ra_d == dq);
          end
        end else if (fits) begin
          res_num  <= fneg ? (~nq[W-1:0] + W'(1)) : nq[W-1:0];
          res_den  <= dq[W-1:0];
          is_equal <= 1'b0;
          status   <= STAT_OK;
        end else begin
          res_num  <= '0;
          res_den  <= '0;
          is_equal <= 1'b0;
          status   <= STAT_OVF;
        end
      end
      default: ;
    endcase
  end

endmodule
